// ===== src/sparse_polynomial_add_sub_macros.svh =====
// Assertion macros shared by the sparse polynomial block.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef SPARSE_POLYNOMIAL_ADD_SUB_MACROS_SVH
`define SPARSE_POLYNOMIAL_ADD_SUB_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define SPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/spa_pkg.sv =====
// Package for the sparse polynomial add/sub block: default sizes and request codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

  // Default sizes of the term stores and fields.
  localparam int unsigned MAX_TERMS_DEF  = 32;
  localparam int unsigned EXP_BITS_DEF   = 8;
  localparam int unsigned COEFF_BITS_DEF = 16;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_INS_A = 2'd0,
    REQ_INS_B = 2'd1,
    REQ_ADD   = 2'd2,
    REQ_SUB   = 2'd3
  } req_type_e;

endpackage

`default_nettype wire

// ===== src/spa_store.sv =====
// One term store: coefficient and exponent memories with a registered read port
// and a term count. Depends on spa_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module spa_store import spa_pkg::*; #(
  parameter int unsigned MAX_TERMS  = MAX_TERMS_DEF,
  parameter int unsigned EXP_BITS   = EXP_BITS_DEF,
  parameter int unsigned COEFF_BITS = COEFF_BITS_DEF,
  localparam int unsigned IW = $clog2(MAX_TERMS),
  localparam int unsigned CW = $clog2(MAX_TERMS + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [IW-1:0]         raddr_i,
  output logic      [COEFF_BITS-1:0] rcoeff_o,
  output logic      [EXP_BITS-1:0]   rexp_o,
  input  wire logic                  we_i,
  input  wire logic [IW-1:0]         waddr_i,
  input  wire logic [COEFF_BITS-1:0] wcoeff_i,
  input  wire logic [EXP_BITS-1:0]   wexp_i,
  input  wire logic                  inc_i,
  output logic      [CW-1:0]         count_o
);

  logic [COEFF_BITS-1:0] coeff_mem [MAX_TERMS];
  logic [EXP_BITS-1:0]   exp_mem   [MAX_TERMS];
  logic [CW-1:0]         count_q;

  // Memory write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      coeff_mem[waddr_i] <= wcoeff_i;
      exp_mem[waddr_i]   <= wexp_i;
    end
    rcoeff_o <= coeff_mem[raddr_i];
    rexp_o   <= exp_mem[raddr_i];
  end

  // Number of terms held; grows by one per completed insert.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (inc_i) begin
      count_q <= count_q + CW'(1);
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== src/sparse_polynomial_add_sub.sv =====
// Top level of the sparse polynomial add/sub block: request sequencer, merge buffer
// and output register. Depends on spa_pkg, spa_store and the assertion macro header.
//
//  Channel | Handshake               | Word
//  --------+-------------------------+----------------------------------------------
//  request | in_valid_i / in_ready_o | req_type_i, term_coeff_i, term_exp_i
//  result  | out_valid_o/out_ready_i | out_coeff_o, out_exp_o, term_valid_o,
//          |                         | last_o, status_o
//
// An insert reads and rewrites each stored term that moves up (S_INS_RD, S_INS_CMP), then
// places the new term and sends one ack word; a full store acks at once.
// A merge walks both stores one step a cycle through their read ports, then replays the
// merge buffer: each run of equal exponents is scanned (S_SCN_START, S_SCN_FIRST,
// S_SCN_NEXT) and then sent word by word (S_EMIT_RD, S_EMIT_WR).
// Reset clears both term counts, the sequencer and the output valid flag; no sweep is needed.
// in_ready_o is high only while the sequencer is idle; a stalled result word holds the
// sequencer in place until it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_polynomial_add_sub_macros.svh"

module sparse_polynomial_add_sub import spa_pkg::*; #(
  parameter int unsigned MAX_TERMS  = MAX_TERMS_DEF,
  parameter int unsigned EXP_BITS   = EXP_BITS_DEF,
  parameter int unsigned COEFF_BITS = COEFF_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic        [1:0]            req_type_i,
  input  wire logic signed [COEFF_BITS-1:0] term_coeff_i,
  input  wire logic        [EXP_BITS-1:0]   term_exp_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed      [COEFF_BITS:0]   out_coeff_o,
  output logic             [EXP_BITS-1:0]   out_exp_o,
  output logic                              term_valid_o,
  output logic                              last_o,
  output logic                              status_o
);

  localparam int unsigned IW  = $clog2(MAX_TERMS);
  localparam int unsigned CW  = $clog2(MAX_TERMS + 1);
  localparam int unsigned BD  = 2 * MAX_TERMS;
  localparam int unsigned BW  = $clog2(BD);
  localparam int unsigned BCW = $clog2(BD + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INS_RD    = 4'd1;
  localparam logic [3:0] S_INS_CMP   = 4'd2;
  localparam logic [3:0] S_ACK       = 4'd3;
  localparam logic [3:0] S_MRG_RD    = 4'd4;
  localparam logic [3:0] S_MRG_CMP   = 4'd5;
  localparam logic [3:0] S_EMPTY     = 4'd6;
  localparam logic [3:0] S_SCN_START = 4'd7;
  localparam logic [3:0] S_SCN_FIRST = 4'd8;
  localparam logic [3:0] S_SCN_NEXT  = 4'd9;
  localparam logic [3:0] S_EMIT_RD   = 4'd10;
  localparam logic [3:0] S_EMIT_WR   = 4'd11;

  logic [3:0] state_q, state_d;

  // Latched request word.
  req_type_e             req_q, req_d;
  logic [COEFF_BITS-1:0] cin_q, cin_d;
  logic [EXP_BITS-1:0]   ein_q, ein_d;
  logic                  full_q, full_d;

  // Walk pointers.
  logic [CW-1:0]       ptr_q, ptr_d, ptr_m1;
  logic [CW-1:0]       i_q, i_d, j_q, j_d, i_nx, j_nx;
  logic [BCW-1:0]      n_q, n_d, n_nx;
  logic [BCW-1:0]      s_q, s_d, p_q, p_d, t_q, t_d, e_q, e_d;
  logic [BCW-1:0]      s_p1, p_p1;
  logic [EXP_BITS-1:0] run_exp_q, run_exp_d;
  logic                run_last;

  // Term store ports.
  logic [IW-1:0]         a_raddr, b_raddr, st_waddr;
  logic [COEFF_BITS-1:0] a_rcoeff, b_rcoeff, st_wcoeff, ins_rcoeff;
  logic [EXP_BITS-1:0]   a_rexp, b_rexp, st_wexp, ins_rexp;
  logic [CW-1:0]         a_cnt, b_cnt, ins_cnt;
  logic                  st_we, st_inc, sel_b, a_we, b_we, a_inc, b_inc;

  // Merge buffer.
  logic signed [COEFF_BITS:0] rb_coeff_mem [BD];
  logic [EXP_BITS-1:0]        rb_exp_mem   [BD];
  logic                       rb_we;
  logic [BW-1:0]              rb_waddr, rb_raddr;
  logic signed [COEFF_BITS:0] rb_rcoeff;
  logic [EXP_BITS-1:0]        rb_rexp;

  // Shared compare and add unit.
  logic [EXP_BITS-1:0]        cmp_x, cmp_y;
  logic                       cmp_gt, cmp_eq;
  logic                       a_has, b_has, take_a, take_b, both;
  logic signed [COEFF_BITS:0] add_x, add_y, add_res;
  logic                       sub_op;

  // Output register.
  logic                       out_valid_q, out_load, slot_free;
  logic signed [COEFF_BITS:0] o_coeff_q, o_coeff_d;
  logic [EXP_BITS-1:0]        o_exp_q, o_exp_d;
  logic                       o_tv_q, o_tv_d, o_last_q, o_last_d, o_stat_q, o_stat_d;

  // Term stores A and B.
  assign sel_b = (req_q == REQ_INS_B);
  assign a_we  = st_we & ~sel_b;
  assign b_we  = st_we & sel_b;
  assign a_inc = st_inc & ~sel_b;
  assign b_inc = st_inc & sel_b;

  spa_store #(
    .MAX_TERMS  (MAX_TERMS),
    .EXP_BITS   (EXP_BITS),
    .COEFF_BITS (COEFF_BITS)
  ) u_store_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .raddr_i  (a_raddr),
    .rcoeff_o (a_rcoeff),
    .rexp_o   (a_rexp),
    .we_i     (a_we),
    .waddr_i  (st_waddr),
    .wcoeff_i (st_wcoeff),
    .wexp_i   (st_wexp),
    .inc_i    (a_inc),
    .count_o  (a_cnt)
  );

  spa_store #(
    .MAX_TERMS  (MAX_TERMS),
    .EXP_BITS   (EXP_BITS),
    .COEFF_BITS (COEFF_BITS)
  ) u_store_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .raddr_i  (b_raddr),
    .rcoeff_o (b_rcoeff),
    .rexp_o   (b_rexp),
    .we_i     (b_we),
    .waddr_i  (st_waddr),
    .wcoeff_i (st_wcoeff),
    .wexp_i   (st_wexp),
    .inc_i    (b_inc),
    .count_o  (b_cnt)
  );

  assign ins_rcoeff = sel_b ? b_rcoeff : a_rcoeff;
  assign ins_rexp   = sel_b ? b_rexp : a_rexp;
  assign ins_cnt    = sel_b ? b_cnt : a_cnt;

  // Merge buffer: written during the walk, read back during the replay.
  always_ff @(posedge clk_i) begin
    if (rb_we) begin
      rb_coeff_mem[rb_waddr] <= add_res;
      rb_exp_mem[rb_waddr]   <= take_a ? a_rexp : b_rexp;
    end
    rb_rcoeff <= rb_coeff_mem[rb_raddr];
    rb_rexp   <= rb_exp_mem[rb_raddr];
  end

  // Operand selection for the shared comparator.
  always_comb begin
    cmp_x = '0;
    cmp_y = '0;
    case (state_q)
      S_INS_CMP: begin
        cmp_x = ins_rexp;
        cmp_y = ein_q;
      end
      S_MRG_CMP: begin
        cmp_x = a_rexp;
        cmp_y = b_rexp;
      end
      S_SCN_NEXT: begin
        cmp_x = rb_rexp;
        cmp_y = run_exp_q;
      end
      default: begin
        cmp_x = '0;
        cmp_y = '0;
      end
    endcase
  end

  assign cmp_gt = (cmp_x > cmp_y);
  assign cmp_eq = (cmp_x == cmp_y);

  // Merge step decision: which store supplies the next term.
  assign a_has  = (i_q < a_cnt);
  assign b_has  = (j_q < b_cnt);
  assign take_a = a_has & (~b_has | cmp_gt | cmp_eq);
  assign take_b = b_has & (~a_has | ~cmp_gt);
  assign both   = take_a & take_b;

  // Shared adder: A plus or minus B, with an unused side forced to zero.
  assign sub_op  = (req_q == REQ_SUB);
  assign add_x   = take_a ? $signed({a_rcoeff[COEFF_BITS-1], a_rcoeff}) : '0;
  assign add_y   = take_b ? $signed({b_rcoeff[COEFF_BITS-1], b_rcoeff}) : '0;
  assign add_res = sub_op ? (add_x - add_y) : (add_x + add_y);

  assign ptr_m1   = ptr_q - CW'(1);
  assign i_nx     = i_q + CW'(take_a);
  assign j_nx     = j_q + CW'(take_b);
  assign n_nx     = n_q + BCW'(rb_we);
  assign s_p1     = s_q + BCW'(1);
  assign p_p1     = p_q + BCW'(1);
  assign run_last = (t_q == (n_q - BCW'(1)));
  assign rb_waddr = n_q[BW-1:0];

  assign slot_free  = ~out_valid_q | out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    cin_d     = cin_q;
    ein_d     = ein_q;
    full_d    = full_q;
    ptr_d     = ptr_q;
    i_d       = i_q;
    j_d       = j_q;
    n_d       = n_q;
    s_d       = s_q;
    p_d       = p_q;
    t_d       = t_q;
    e_d       = e_q;
    run_exp_d = run_exp_q;
    a_raddr   = '0;
    b_raddr   = '0;
    st_we     = 1'b0;
    st_inc    = 1'b0;
    st_waddr  = ptr_q[IW-1:0];
    st_wcoeff = cin_q;
    st_wexp   = ein_q;
    rb_we     = 1'b0;
    rb_raddr  = '0;
    out_load  = 1'b0;
    o_coeff_d = '0;
    o_exp_d   = '0;
    o_tv_d    = 1'b0;
    o_last_d  = 1'b0;
    o_stat_d  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = req_type_e'(req_type_i);
          cin_d = term_coeff_i;
          ein_d = term_exp_i;
          i_d   = '0;
          j_d   = '0;
          n_d   = '0;
          case (req_type_e'(req_type_i))
            REQ_INS_A, REQ_INS_B: begin
              ptr_d = (req_type_e'(req_type_i) == REQ_INS_B) ? b_cnt : a_cnt;
              if (ptr_d == CW'(MAX_TERMS)) begin
                full_d  = 1'b1;
                state_d = S_ACK;
              end else begin
                full_d  = 1'b0;
                state_d = S_INS_RD;
              end
            end
            default: begin
              full_d  = 1'b0;
              state_d = S_MRG_RD;
            end
          endcase
        end
      end

      // Insert: walk down from the top, moving each term with an exponent not
      // above the new one up by one place, then drop the new term in the gap.
      S_INS_RD: begin
        if (ptr_q == '0) begin
          st_we    = 1'b1;
          st_inc   = 1'b1;
          st_waddr = '0;
          state_d  = S_ACK;
        end else begin
          a_raddr = ptr_m1[IW-1:0];
          b_raddr = ptr_m1[IW-1:0];
          state_d = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        st_we = 1'b1;
        if (cmp_gt) begin
          st_inc  = 1'b1;
          state_d = S_ACK;
        end else begin
          st_wcoeff = ins_rcoeff;
          st_wexp   = ins_rexp;
          ptr_d     = ptr_m1;
          state_d   = S_INS_RD;
        end
      end

      S_ACK: begin
        if (slot_free) begin
          out_load = 1'b1;
          o_last_d = 1'b1;
          o_stat_d = full_q;
          state_d  = S_IDLE;
        end
      end

      // Merge walk: one step per cycle, the next reads issued from the next pointers.
      S_MRG_RD: begin
        a_raddr = i_q[IW-1:0];
        b_raddr = j_q[IW-1:0];
        if (a_cnt == '0 && b_cnt == '0) begin
          state_d = S_EMPTY;
        end else begin
          state_d = S_MRG_CMP;
        end
      end

      S_MRG_CMP: begin
        rb_we   = ~(both && add_res == '0);
        i_d     = i_nx;
        j_d     = j_nx;
        n_d     = n_nx;
        a_raddr = i_nx[IW-1:0];
        b_raddr = j_nx[IW-1:0];
        if (i_nx >= a_cnt && j_nx >= b_cnt) begin
          s_d     = '0;
          state_d = (n_nx == '0) ? S_EMPTY : S_SCN_START;
        end
      end

      S_EMPTY: begin
        if (slot_free) begin
          out_load = 1'b1;
          o_last_d = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // Replay: find the end of the run of equal exponents that starts at s.
      S_SCN_START: begin
        rb_raddr = s_q[BW-1:0];
        state_d  = S_SCN_FIRST;
      end

      S_SCN_FIRST: begin
        run_exp_d = rb_rexp;
        if (s_p1 < n_q) begin
          p_d      = s_p1;
          rb_raddr = s_p1[BW-1:0];
          state_d  = S_SCN_NEXT;
        end else begin
          t_d     = s_q;
          state_d = S_EMIT_RD;
        end
      end

      S_SCN_NEXT: begin
        if (cmp_eq) begin
          if (p_p1 < n_q) begin
            p_d      = p_p1;
            rb_raddr = p_p1[BW-1:0];
          end else begin
            t_d     = p_q;
            state_d = S_EMIT_RD;
          end
        end else begin
          t_d     = p_q - BCW'(1);
          state_d = S_EMIT_RD;
        end
      end

      // Replay: send the run from its end back to its start.
      S_EMIT_RD: begin
        rb_raddr = t_q[BW-1:0];
        e_d      = t_q;
        state_d  = S_EMIT_WR;
      end

      S_EMIT_WR: begin
        rb_raddr = e_q[BW-1:0];
        if (slot_free) begin
          out_load  = 1'b1;
          o_coeff_d = rb_rcoeff;
          o_exp_d   = rb_rexp;
          o_tv_d    = 1'b1;
          o_last_d  = run_last && (e_q == s_q);
          if (e_q == s_q) begin
            s_d     = t_q + BCW'(1);
            state_d = run_last ? S_IDLE : S_SCN_START;
          end else begin
            e_d      = e_q - BCW'(1);
            rb_raddr = e_d[BW-1:0];
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cin_q     <= cin_d;
    ein_q     <= ein_d;
    full_q    <= full_d;
    ptr_q     <= ptr_d;
    i_q       <= i_d;
    j_q       <= j_d;
    n_q       <= n_d;
    s_q       <= s_d;
    p_q       <= p_d;
    t_q       <= t_d;
    e_q       <= e_d;
    run_exp_q <= run_exp_d;
    if (out_load) begin
      o_coeff_q <= o_coeff_d;
      o_exp_q   <= o_exp_d;
      o_tv_q    <= o_tv_d;
      o_last_q  <= o_last_d;
      o_stat_q  <= o_stat_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_coeff_o  = o_coeff_q;
  assign out_exp_o    = o_exp_q;
  assign term_valid_o = o_tv_q;
  assign last_o       = o_last_q;
  assign status_o     = o_stat_q;

  // Checks on the sequencer.
  `SPA_ASSERT_NXT(a_last_then_idle, out_load && o_last_d, state_q == S_IDLE, "last word not followed by idle")
  `SPA_ASSERT_IMP(a_load_slot_free, out_load, slot_free, "output word overwritten before taken")
  `SPA_ASSERT_IMP(a_buf_in_range, rb_we, n_q < BCW'(BD), "merge buffer write beyond its depth")
  `SPA_ASSERT_IMP(a_no_overfill, st_inc, ins_cnt != CW'(MAX_TERMS), "insert into a full store")

endmodule

`default_nettype wire

// ===== sim/spa_result_checker.sv =====
// Result checker for the sparse polynomial add/sub block: watches both channels,
// predicts the result words of every accepted request and compares them. Depends on spa_pkg.
`timescale 1ns / 1ps

module spa_result_checker
  import spa_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [1:0]                        req_type_i,
  input  logic signed [COEFF_BITS_DEF-1:0]  term_coeff_i,
  input  logic [EXP_BITS_DEF-1:0]           term_exp_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [COEFF_BITS_DEF:0]    out_coeff_i,
  input  logic [EXP_BITS_DEF-1:0]           out_exp_i,
  input  logic                              term_valid_i,
  input  logic                              last_i,
  input  logic                              status_i,
  output int                                n_due_o,
  output int                                n_errors_o
);

  localparam int CW    = COEFF_BITS_DEF;
  localparam int EW    = EXP_BITS_DEF;
  localparam int DEPTH = MAX_TERMS_DEF;

  // Store selectors.
  localparam int STORE_A = 0;
  localparam int STORE_B = 1;

  typedef struct packed {
    logic signed [CW:0] coeff;
    logic [EW-1:0]      expo;
    logic               term_valid;
    logic               last;
    logic               status;
  } result_word_t;

  // Shadow copy of the two term stores, sorted by descending exponent.
  logic signed [CW-1:0] held_coeff [2][DEPTH];
  logic [EW-1:0]        held_expo  [2][DEPTH];
  int                   held_cnt   [2];

  // Result words still owed by the block, oldest first.
  result_word_t words_due [$];

  // Place one term into a store; a full store drops it and flags the ack word.
  function automatic void store_term(input int sel, input logic signed [CW-1:0] c,
                                     input logic [EW-1:0] e);
    result_word_t ack;
    int pos;
    int k;
    ack = '0;
    ack.last = 1'b1;
    if (held_cnt[sel] >= DEPTH) begin
      ack.status = 1'b1;
    end else begin
      pos = 0;
      while (pos < held_cnt[sel] && held_expo[sel][pos] > e) pos++;
      for (k = held_cnt[sel]; k > pos; k--) begin
        held_coeff[sel][k] = held_coeff[sel][k-1];
        held_expo[sel][k]  = held_expo[sel][k-1];
      end
      held_coeff[sel][pos] = c;
      held_expo[sel][pos]  = e;
      held_cnt[sel]++;
    end
    words_due.push_back(ack);
  endfunction

  // Merge A with B (or with -B) and queue the resulting term words.
  function automatic void merge_stores(input logic negate_b);
    logic signed [CW:0] mc [2*DEPTH];
    logic [EW-1:0]      me [2*DEPTH];
    logic signed [CW:0] ac;
    logic signed [CW:0] bc;
    logic signed [CW:0] sum_c;
    result_word_t       w;
    int n;
    int i;
    int j;
    int s;
    int t;
    int lo;
    int hi;
    n = 0;
    i = 0;
    j = 0;
    ac = '0;
    bc = '0;
    while (i < held_cnt[STORE_A] || j < held_cnt[STORE_B]) begin
      if (i < held_cnt[STORE_A]) ac = held_coeff[STORE_A][i];
      if (j < held_cnt[STORE_B]) begin
        bc = held_coeff[STORE_B][j];
        if (negate_b) bc = -bc;
      end
      if (i < held_cnt[STORE_A] && j < held_cnt[STORE_B] &&
          held_expo[STORE_A][i] == held_expo[STORE_B][j]) begin
        // Matching exponents combine; a zero sum is dropped.
        sum_c = ac + bc;
        if (sum_c != 0) begin
          mc[n] = sum_c;
          me[n] = held_expo[STORE_A][i];
          n++;
        end
        i++;
        j++;
      end else if (j >= held_cnt[STORE_B] ||
                   (i < held_cnt[STORE_A] &&
                    held_expo[STORE_A][i] > held_expo[STORE_B][j])) begin
        mc[n] = ac;
        me[n] = held_expo[STORE_A][i];
        n++;
        i++;
      end else begin
        mc[n] = bc;
        me[n] = held_expo[STORE_B][j];
        n++;
        j++;
      end
    end

    if (n == 0) begin
      w = '0;
      w.last = 1'b1;
      words_due.push_back(w);
      return;
    end

    // Terms sharing one exponent leave newest first, the reverse of the walk.
    s = 0;
    while (s < n) begin
      t = s;
      while (t + 1 < n && me[t+1] == me[s]) t++;
      lo = s;
      hi = t;
      while (lo < hi) begin
        sum_c  = mc[lo];
        mc[lo] = mc[hi];
        mc[hi] = sum_c;
        lo++;
        hi--;
      end
      s = t + 1;
    end

    for (i = 0; i < n; i++) begin
      w = '0;
      w.coeff      = mc[i];
      w.expo       = me[i];
      w.term_valid = 1'b1;
      w.last       = (i == n - 1);
      words_due.push_back(w);
    end
  endfunction

  // Compare one accepted result word with the oldest prediction.
  function automatic void check_word();
    result_word_t w;
    if (words_due.size() == 0) begin
      $error("result word with no request outstanding: coeff %0d exp %0d",
             out_coeff_i, out_exp_i);
      n_errors_o++;
      return;
    end
    w = words_due.pop_front();
    if (out_coeff_i !== w.coeff) begin
      $error("out_coeff: expected %0d, got %0d", w.coeff, out_coeff_i);
      n_errors_o++;
    end
    if (out_exp_i !== w.expo) begin
      $error("out_exp: expected %0d, got %0d", w.expo, out_exp_i);
      n_errors_o++;
    end
    if (term_valid_i !== w.term_valid) begin
      $error("term_valid: expected %0b, got %0b", w.term_valid, term_valid_i);
      n_errors_o++;
    end
    if (last_i !== w.last) begin
      $error("last: expected %0b, got %0b", w.last, last_i);
      n_errors_o++;
    end
    if (status_i !== w.status) begin
      $error("status: expected %0b, got %0b", w.status, status_i);
      n_errors_o++;
    end
  endfunction

  // Both channels are sampled at the rising edge; requests first, then results.
  // The error count starts from zero while reset is held.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt[STORE_A] = 0;
      held_cnt[STORE_B] = 0;
      words_due.delete();
      n_due_o    = 0;
      n_errors_o = 0;
    end else begin
      if ($isunknown(out_valid_i) || $isunknown(in_ready_i)) begin
        $error("handshake signal unknown: out_valid %b, in_ready %b",
               out_valid_i, in_ready_i);
        n_errors_o++;
      end
      if (in_valid_i && in_ready_i) begin
        case (req_type_i)
          REQ_INS_A: store_term(STORE_A, term_coeff_i, term_exp_i);
          REQ_INS_B: store_term(STORE_B, term_coeff_i, term_exp_i);
          REQ_ADD:   merge_stores(1'b0);
          REQ_SUB:   merge_stores(1'b1);
          default:   ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_word();
      n_due_o = words_due.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the sparse polynomial add/sub block: clock, reset, request stimulus
// and verdict. Depends on spa_pkg, sparse_polynomial_add_sub and spa_result_checker.
`timescale 1ns / 1ps

module tb;
  import spa_pkg::*;

  localparam int CW    = COEFF_BITS_DEF;
  localparam int EW    = EXP_BITS_DEF;
  localparam int DEPTH = MAX_TERMS_DEF;
  localparam int N_RANDOM   = 460;
  localparam int PHASE_LEN  = 58;

  typedef enum int {
    PH_FREE,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH
  } idle_phase_e;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           req_type_i   = REQ_INS_A;
  logic signed [CW-1:0] term_coeff_i = '0;
  logic [EW-1:0]        term_exp_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic signed [CW:0]   out_coeff_o;
  logic [EW-1:0]        out_exp_o;
  logic                 term_valid_o;
  logic                 last_o;
  logic                 status_o;

  int n_due;
  int n_errors;

  // Idle rates in percent of cycles for the two sides.
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  // Stimulus bookkeeping: fill levels and the terms that went into A.
  int            a_fill = 0;
  int            b_fill = 0;
  logic [CW-1:0] a_hist_coeff [$];
  logic [EW-1:0] a_hist_expo  [$];

  always #4 clk_i = ~clk_i;

  sparse_polynomial_add_sub DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .term_coeff_i (term_coeff_i),
    .term_exp_i   (term_exp_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_coeff_o  (out_coeff_o),
    .out_exp_o    (out_exp_o),
    .term_valid_o (term_valid_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

  spa_result_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .req_type_i   (req_type_i),
    .term_coeff_i (term_coeff_i),
    .term_exp_i   (term_exp_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_coeff_i  (out_coeff_o),
    .out_exp_i    (out_exp_o),
    .term_valid_i (term_valid_o),
    .last_i       (last_o),
    .status_i     (status_o),
    .n_due_o      (n_due),
    .n_errors_o   (n_errors)
  );

  // The result side stalls at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Offer one request word after a random idle stretch and wait for it to be taken.
  task automatic send_word(input req_type_e req, input logic [CW-1:0] c,
                           input logic [EW-1:0] e);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    term_coeff_i <= c;
    term_exp_i   <= e;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Insert requests also keep the fill levels and the history of A up to date.
  task automatic send_insert(input req_type_e req, input logic [CW-1:0] c,
                             input logic [EW-1:0] e);
    if (req == REQ_INS_A) begin
      if (a_fill < DEPTH) begin
        a_fill++;
        a_hist_coeff.push_back(c);
        a_hist_expo.push_back(e);
      end
    end else if (b_fill < DEPTH) begin
      b_fill++;
    end
    send_word(req, c, e);
  endtask

  // Coefficients lean on the extremes, zero and small values.
  function automatic logic [CW-1:0] pick_coeff();
    int v;
    case ($urandom_range(0, 9))
      0: v = 32'h0000_8000;
      1: v = 32'h0000_7fff;
      2: v = 0;
      3: v = $urandom_range(0, 6) - 3;
      default: v = $urandom();
    endcase
    return v[CW-1:0];
  endfunction

  // Exponents come often from narrow bands so that collisions and runs are common.
  function automatic logic [EW-1:0] pick_expo();
    int v;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: v = $urandom_range(0, 7);
      7, 8, 9:             v = $urandom_range(248, 255);
      default:             v = $urandom_range(0, 255);
    endcase
    return v[EW-1:0];
  endfunction

  function automatic void set_phase(input idle_phase_e ph);
    case (ph)
      PH_FREE:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      PH_SRC_IDLE:   begin src_idle_pct = 74; sink_stall_pct = 0;  end
      PH_SINK_STALL: begin src_idle_pct = 0;  sink_stall_pct = 74; end
      default:       begin src_idle_pct = 24; sink_stall_pct = 24; end
    endcase
  endfunction

  // One random request: merges get more frequent once both stores are full.
  task automatic send_random();
    int            merge_pct;
    int            k;
    logic [CW-1:0] c;
    logic [EW-1:0] e;
    merge_pct = (a_fill >= DEPTH && b_fill >= DEPTH) ? 60 : 30;
    c = pick_coeff();
    e = pick_expo();
    if ($urandom_range(0, 99) < merge_pct) begin
      send_word($urandom_range(0, 1) ? REQ_SUB : REQ_ADD, c, e);
    end else if ($urandom_range(0, 1)) begin
      send_insert(REQ_INS_A, c, e);
    end else begin
      // B often mirrors a term of A, so that sums or differences cancel.
      if (a_hist_coeff.size() != 0 && $urandom_range(0, 99) < 35) begin
        k = $urandom_range(0, a_hist_coeff.size() - 1);
        e = a_hist_expo[k];
        c = $urandom_range(0, 1) ? a_hist_coeff[k] : -a_hist_coeff[k];
      end
      send_insert(REQ_INS_B, c, e);
    end
  endtask

  // Main sequence: reset, directed requests, random requests, drain, verdict.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty merges, B-only terms, extremes, cancellation, repeats.
    set_phase(PH_FREE);
    send_word(REQ_ADD, 16'h0000, 8'h00);
    send_word(REQ_SUB, 16'hffff, 8'hff);
    send_insert(REQ_INS_B, 16'h0005, 8'd7);
    send_insert(REQ_INS_B, 16'h8000, 8'd0);
    send_word(REQ_SUB, 16'h0000, 8'h00);
    send_insert(REQ_INS_A, 16'h7fff, 8'd255);
    send_insert(REQ_INS_A, 16'h8000, 8'd0);
    send_insert(REQ_INS_A, 16'h0000, 8'd100);
    send_insert(REQ_INS_B, 16'h7fff, 8'd255);
    send_word(REQ_ADD, 16'h0000, 8'h00);
    send_word(REQ_SUB, 16'h0000, 8'h00);
    send_insert(REQ_INS_A, 16'h0003, 8'd100);
    send_insert(REQ_INS_A, 16'hffff, 8'd100);
    send_insert(REQ_INS_B, 16'h0001, 8'd100);
    send_insert(REQ_INS_B, 16'h0000, 8'd50);
    send_word(REQ_ADD, 16'h0000, 8'h00);
    send_word(REQ_SUB, 16'h0000, 8'h00);
    send_insert(REQ_INS_A, 16'h5555, 8'h55);
    send_insert(REQ_INS_B, 16'haaaa, 8'haa);
    send_word(REQ_ADD, 16'h0000, 8'h00);

    // Random part, cycling through the idle phases.
    for (int idx = 0; idx < N_RANDOM; idx++) begin
      set_phase(idle_phase_e'((idx / PHASE_LEN) % 4));
      send_random();
    end
    in_valid_i <= 1'b0;

    // Wait for every owed word, then watch a while for stray ones.
    @(posedge clk_i);
    while (n_due != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
